// ===== rtl/core/ihrc_pkg.sv =====
// Shared types and constants for the IPv4 header receive check.
`timescale 1ns / 1ps
`default_nettype none

package ihrc_pkg;

  // Verdict codes
  localparam logic [2:0] V_DELIVER     = 3'd0;
  localparam logic [2:0] V_FRAGMENT    = 3'd1;
  localparam logic [2:0] V_NOT_FOR_US  = 3'd2;
  localparam logic [2:0] V_SHORT       = 3'd3;
  localparam logic [2:0] V_BAD_VERSION = 3'd4;
  localparam logic [2:0] V_BAD_HLEN    = 3'd5;
  localparam logic [2:0] V_BAD_CKSUM   = 3'd6;
  localparam logic [2:0] V_BAD_LEN     = 3'd7;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_BROADCAST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_BROADCAST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_NUMBER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_NUMBER         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_ENABLE   = 3'd5;

  // Header byte positions
  localparam logic [5:0] POS_VER_IHL   = 6'd0;
  localparam logic [5:0] POS_TLEN_HI   = 6'd2;
  localparam logic [5:0] POS_TLEN_LO   = 6'd3;
  localparam logic [5:0] POS_FLAGS_HI  = 6'd6;
  localparam logic [5:0] POS_FLAGS_LO  = 6'd7;
  localparam logic [5:0] POS_PROTO     = 6'd9;
  localparam logic [5:0] POS_DEST_0    = 6'd16;
  localparam logic [5:0] POS_DEST_1    = 6'd17;
  localparam logic [5:0] POS_DEST_2    = 6'd18;
  localparam logic [5:0] POS_DEST_3    = 6'd19;

  localparam logic [5:0]  COUNT_MAX     = 6'd63;
  localparam logic [5:0]  HDR_MIN_BYTES = 6'd20;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
  localparam logic [31:0] ADDR_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_ZERO     = 32'h0000_0000;

  typedef struct packed {
    logic [31:0] local_address;
    logic [31:0] subnet_broadcast;
    logic [31:0] net_broadcast;
    logic [31:0] subnet_number;
    logic [31:0] net_number;
    logic        broadcast_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    local_address:      32'h0000_0000,
    subnet_broadcast:   32'hFFFF_FFFF,
    net_broadcast:      32'hFFFF_FFFF,
    subnet_number:      32'h0000_0000,
    net_number:         32'h0000_0000,
    broadcast_enable:   1'b1
  };

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  protocol;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
    logic [12:0] fragment_offset;
    logic        more_fragments;
    logic        options_present;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ihrc_byte_if.sv =====
// Input byte channel: valid/ready with one packet byte and end mark.
`timescale 1ns / 1ps
`default_nettype none

interface ihrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ihrc_result_if.sv =====
// Result channel: valid/ready with one header verdict item.
`timescale 1ns / 1ps
`default_nettype none

interface ihrc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  protocol;
  logic [5:0]  header_bytes;
  logic [15:0] payload_length;
  logic [12:0] fragment_offset;
  logic        more_fragments;
  logic        options_present;

  modport source (output valid, output verdict, output protocol, output header_bytes,
                  output payload_length, output fragment_offset, output more_fragments,
                  output options_present, input ready);
  modport sink   (input valid, input verdict, input protocol, input header_bytes,
                  input payload_length, input fragment_offset, input more_fragments,
                  input options_present, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ihrc_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
`timescale 1ns / 1ps
`default_nettype none

interface ihrc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ihrc_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ihrc_hdr_track.sv =====
// Per-packet header capture, checksum accumulation and verdict logic.
`timescale 1ns / 1ps
`default_nettype none

module ihrc_hdr_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_packet,
  input  ihrc_pkg::cfg_t    cfg_regs,
  output logic              push,
  output ihrc_pkg::result_t result
);

  logic [5:0]  byte_count, byte_count_next;
  logic [15:0] sum_acc, sum_acc_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [7:0]  version_ihl, version_ihl_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] flags_offset, flags_offset_next;
  logic [7:0]  proto_hold, proto_hold_next;
  logic [31:0] dest_hold, dest_hold_next;
  logic        verdict_given;

  logic [16:0] word_sum;
  logic [3:0]  ihl;
  logic [5:0]  hlen;
  logic        hdr_done;
  logic        dest_ours;
  logic [2:0]  full_verdict;
  logic [2:0]  hdr_verdict;
  logic [2:0]  verdict;
  logic        emit;

  always_comb begin
    version_ihl_next    = version_ihl;
    total_length_next   = total_length;
    flags_offset_next   = flags_offset;
    proto_hold_next     = proto_hold;
    dest_hold_next      = dest_hold;
    high_byte_hold_next = high_byte_hold;
    sum_acc_next        = sum_acc;
    word_sum            = {1'b0, sum_acc} + {1'b0, high_byte_hold, data_byte};

    unique case (byte_count) inside
      ihrc_pkg::POS_VER_IHL:  version_ihl_next = data_byte;
      ihrc_pkg::POS_TLEN_HI:  total_length_next = {data_byte, total_length[7:0]};
      ihrc_pkg::POS_TLEN_LO:  total_length_next = {total_length[15:8], data_byte};
      ihrc_pkg::POS_FLAGS_HI: flags_offset_next = {data_byte, flags_offset[7:0]};
      ihrc_pkg::POS_FLAGS_LO: flags_offset_next = {flags_offset[15:8], data_byte};
      ihrc_pkg::POS_PROTO:    proto_hold_next = data_byte;
      ihrc_pkg::POS_DEST_0, ihrc_pkg::POS_DEST_1,
      ihrc_pkg::POS_DEST_2, ihrc_pkg::POS_DEST_3:
        dest_hold_next = {dest_hold[23:0], data_byte};
      default: ;
    endcase

    // even byte opens a word, odd byte closes it with end-around carry
    if (!byte_count[0]) begin
      high_byte_hold_next = data_byte;
    end else if (word_sum[16]) begin
      sum_acc_next = word_sum[15:0] + 16'd1;
    end else begin
      sum_acc_next = word_sum[15:0];
    end

    byte_count_next = (byte_count < ihrc_pkg::COUNT_MAX) ? byte_count + 6'd1
                                                          : ihrc_pkg::COUNT_MAX;
  end

  always_comb begin
    ihl  = version_ihl_next[3:0];
    hlen = {ihl, 2'b00};

    dest_ours = (dest_hold_next == cfg_regs.local_address) ||
                (cfg_regs.broadcast_enable &&
                 ((dest_hold_next == cfg_regs.subnet_broadcast) ||
                  (dest_hold_next == cfg_regs.net_broadcast) ||
                  (dest_hold_next == cfg_regs.subnet_number) ||
                  (dest_hold_next == cfg_regs.net_number))) ||
                (dest_hold_next == ihrc_pkg::ADDR_ONES) ||
                (dest_hold_next == ihrc_pkg::ADDR_ZERO);

    if (sum_acc_next != ihrc_pkg::SUM_GOOD) begin
      full_verdict = ihrc_pkg::V_BAD_CKSUM;
    end else if (total_length_next < {10'd0, hlen}) begin
      full_verdict = ihrc_pkg::V_BAD_LEN;
    end else if (!dest_ours) begin
      full_verdict = ihrc_pkg::V_NOT_FOR_US;
    end else if (flags_offset_next[13:0] != 14'd0) begin
      full_verdict = ihrc_pkg::V_FRAGMENT;
    end else begin
      full_verdict = ihrc_pkg::V_DELIVER;
    end

    hdr_done    = 1'b0;
    hdr_verdict = full_verdict;
    if (byte_count_next == ihrc_pkg::HDR_MIN_BYTES) begin
      if (version_ihl_next[7:4] != ihrc_pkg::IP_VERSION) begin
        hdr_done    = 1'b1;
        hdr_verdict = ihrc_pkg::V_BAD_VERSION;
      end else if (ihl < ihrc_pkg::MIN_IHL) begin
        hdr_done    = 1'b1;
        hdr_verdict = ihrc_pkg::V_BAD_HLEN;
      end else if (hlen == ihrc_pkg::HDR_MIN_BYTES) begin
        hdr_done    = 1'b1;
      end
    end else if (byte_count_next > ihrc_pkg::HDR_MIN_BYTES && byte_count_next == hlen) begin
      hdr_done = 1'b1;
    end

    // header verdict wins over a packet end on the same byte
    verdict = hdr_done ? hdr_verdict : ihrc_pkg::V_SHORT;
    emit    = !verdict_given && (hdr_done || end_of_packet);
    push    = step && emit;

    result.verdict         = verdict;
    result.protocol        = proto_hold_next;
    result.header_bytes    = hlen;
    result.payload_length  = (verdict <= ihrc_pkg::V_NOT_FOR_US)
                             ? total_length_next - {10'd0, hlen} : 16'd0;
    result.fragment_offset = flags_offset_next[12:0];
    result.more_fragments  = flags_offset_next[13];
    result.options_present = (ihl > ihrc_pkg::MIN_IHL);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_packet)) begin
      byte_count     <= '0;
      sum_acc        <= '0;
      high_byte_hold <= '0;
      version_ihl    <= '0;
      total_length   <= '0;
      flags_offset   <= '0;
      proto_hold     <= '0;
      dest_hold      <= '0;
      verdict_given  <= 1'b0;
    end else if (step && !verdict_given) begin
      byte_count     <= byte_count_next;
      sum_acc        <= sum_acc_next;
      high_byte_hold <= high_byte_hold_next;
      version_ihl    <= version_ihl_next;
      total_length   <= total_length_next;
      flags_offset   <= flags_offset_next;
      proto_hold     <= proto_hold_next;
      dest_hold      <= dest_hold_next;
      verdict_given  <= emit;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ipv4_header_receive_check_unit.sv =====
// IPv4 header receive check: top level with input register and result skid.
//
// Bytes of a received packet enter on byte_in, header first, one item per
// cycle while byte_in.ready allows; end_of_packet marks the last byte. Each
// packet yields exactly one item on result_out: the header verdict as soon
// as 20 bytes or the full header have arrived, or a short verdict if the
// packet ends first. Bytes after the verdict are consumed silently up to
// end_of_packet. Address registers are written through cfg, which is always
// ready; write them only while no packet is in flight.
// A deciding byte passes the input register; its result is then registered
// in a result slot. Throughput: one byte per cycle while a result slot is
// free, set by the single pass of capture, checksum add and address compare.
// When result_out stalls, a second result is held in a skid register, so
// input keeps flowing until both result slots are full; byte_in.ready then
// follows result_out.ready.
// Reset (synchronous, active high) clears the packet state, empties both
// pipeline stages and restores the register defaults. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_header_receive_check_unit (
  input  logic          clk,
  input  logic          rst,
  ihrc_byte_if.sink     byte_in,
  ihrc_result_if.source result_out,
  ihrc_cfg_if.sink      cfg
);

  ihrc_pkg::cfg_t    cfg_regs;
  ihrc_pkg::result_t push_data;
  ihrc_pkg::result_t out_reg;
  ihrc_pkg::result_t skid_reg;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eop;
  logic       s1_adv;
  logic       push;
  logic       pop;
  logic       out_valid;
  logic       skid_valid;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= ihrc_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ihrc_pkg::CFG_LOCAL_ADDRESS:      cfg_regs.local_address      <= cfg.wdata;
        ihrc_pkg::CFG_SUBNET_BROADCAST:   cfg_regs.subnet_broadcast   <= cfg.wdata;
        ihrc_pkg::CFG_NET_BROADCAST:      cfg_regs.net_broadcast      <= cfg.wdata;
        ihrc_pkg::CFG_SUBNET_NUMBER:      cfg_regs.subnet_number      <= cfg.wdata;
        ihrc_pkg::CFG_NET_NUMBER:         cfg_regs.net_number         <= cfg.wdata;
        ihrc_pkg::CFG_BROADCAST_ENABLE:   cfg_regs.broadcast_enable   <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // input register; advance only when a result slot is free
  assign pop            = out_valid && result_out.ready;
  assign s1_adv         = s1_valid && (!skid_valid || pop);
  assign byte_in.ready  = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      s1_byte <= byte_in.data_byte;
      s1_eop  <= byte_in.end_of_packet;
    end
  end

  ihrc_hdr_track u_track (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_adv),
    .data_byte     (s1_byte),
    .end_of_packet (s1_eop),
    .cfg_regs      (cfg_regs),
    .push          (push),
    .result        (push_data)
  );

  // result register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
        if (push) begin
          skid_reg <= push_data;
        end
      end else if (push) begin
        out_reg <= push_data;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_reg <= push_data;
      end
    end else if (push) begin
      skid_reg <= push_data;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.verdict         = out_reg.verdict;
  assign result_out.protocol        = out_reg.protocol;
  assign result_out.header_bytes    = out_reg.header_bytes;
  assign result_out.payload_length  = out_reg.payload_length;
  assign result_out.fragment_offset = out_reg.fragment_offset;
  assign result_out.more_fragments  = out_reg.more_fragments;
  assign result_out.options_present = out_reg.options_present;

endmodule

`default_nettype wire

// ===== rtl/core/ihrc_checker.sv =====
// Port-level assertions for the IPv4 header receive check, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ihrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  verdict,
  input logic [7:0]  protocol,
  input logic [5:0]  header_bytes,
  input logic [15:0] payload_length,
  input logic        options_present
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(protocol) &&
                                $stable(payload_length))
    else $error("result changed while stalled");

  a_out_stay: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_err_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict > ihrc_pkg::V_NOT_FOR_US) |-> payload_length == 16'd0)
    else $error("error verdict carries a payload length");

  a_options_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> options_present == (header_bytes > ihrc_pkg::HDR_MIN_BYTES))
    else $error("options flag disagrees with header length");

endmodule

bind ipv4_header_receive_check_unit ihrc_checker u_ihrc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .verdict         (result_out.verdict),
  .protocol        (result_out.protocol),
  .header_bytes    (result_out.header_bytes),
  .payload_length  (result_out.payload_length),
  .options_present (result_out.options_present)
);

`default_nettype wire
